FILE: rtl/core/csq_pkg.sv
package csq_pkg;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned ID_W        = 4;
   localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned INIT_W      = 8;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 9'sd255;
   localparam logic signed [COUNT_W-1:0] COUNT_RESET = 9'sd1;

   typedef enum logic [0:0] {
      FUNC_ACQUIRE = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_WAKE = 1'b1
   } state_type;

   typedef struct packed {
      logic            clear;
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } queue_ctrl_type;

   typedef struct packed {
      logic            full;
      logic            nonempty;
      logic [ID_W-1:0] head_id;
   } queue_stat_type;

endpackage

FILE: rtl/core/csq_req_if.sv
interface csq_req_if;
   import csq_pkg::*;

   logic            valid;
   logic            ready;
   logic [0:0]      func;
   logic [ID_W-1:0] requester_id;

   modport source (output valid, output func, output requester_id, input ready);
   modport sink (input valid, input func, input requester_id, output ready);
endinterface

FILE: rtl/core/csq_rsp_if.sv
interface csq_rsp_if;
   import csq_pkg::*;

   logic               valid;
   logic               ready;
   logic               granted;
   logic               queued;
   logic               wake_valid;
   logic [ID_W-1:0]    wake_id;
   logic [1:0]         status;
   logic [COUNT_W-1:0] count_now;

   modport source (output valid, output granted, output queued, output wake_valid,
                   output wake_id, output status, output count_now, input ready);
   modport sink (input valid, input granted, input queued, input wake_valid,
                 input wake_id, input status, input count_now, output ready);
endinterface

FILE: rtl/core/counting_semaphore_wait_queue.sv
// Counting semaphore with a first-in-first-out queue of waiting requesters.
// req_chan carries one operation per beat: func 0 acquires, func 1 releases;
// requester_id names the thread that acquires. rsp_chan returns one beat per
// request with granted / queued / wake_valid / wake_id, a status code and the
// count after the operation.
// Writing csr_wr_data with csr_wr_en high reloads the count and empties the
// queue; do so only while no request is in flight.
// Latency: a response is registered in the cycle after its request is taken;
// a release that wakes a waiter passes through ST_WAKE first, since the waiter
// id comes out of the registered read port of the id memory.
// Throughput: one request per cycle while responses are taken; a waking release
// blocks new requests while ST_WAKE waits for that memory read.
// A new request is taken while the previous response is being handed off.
// If the receiver stalls, the response register holds and req_chan.ready
// drops until it is taken.
// Reset (synchronous) sets the count to one and empties the queue; the id
// memory itself is not cleared.
module counting_semaphore_wait_queue (
   input  logic                       clock,
   input  logic                       reset,
   csq_req_if.sink                    req_chan,
   csq_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [csq_pkg::INIT_W-1:0] csr_wr_data
);
   import csq_pkg::*;

   state_type                  state_ff, state_in;
   logic signed [COUNT_W-1:0]  count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       granted_ff, granted_in;
   logic                       queued_ff, queued_in;
   logic                       wake_valid_ff, wake_valid_in;
   logic [ID_W-1:0]            wake_id_ff, wake_id_in;
   status_type                 status_ff, status_in;
   logic signed [COUNT_W-1:0]  count_now_ff, count_now_in;

   logic                       free;
   logic                       accept;
   logic signed [COUNT_W-1:0]  count_dec;
   logic signed [COUNT_W-1:0]  count_inc;
   queue_ctrl_type             qctrl;
   queue_stat_type             qstat;

   csq_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (qctrl),
      .stat  (qstat)
   );

   assign free      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept    = free && req_chan.valid;
   assign count_dec = count_ff - 9'sd1;
   assign count_inc = count_ff + 9'sd1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      granted_in    = granted_ff;
      queued_in     = queued_ff;
      wake_valid_in = wake_valid_ff;
      wake_id_in    = wake_id_ff;
      status_in     = status_ff;
      count_now_in  = count_now_ff;
      qctrl.clear   = 1'b0;
      qctrl.push    = 1'b0;
      qctrl.pop     = 1'b0;
      qctrl.push_id = req_chan.requester_id;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               granted_in    = 1'b0;
               queued_in     = 1'b0;
               wake_valid_in = 1'b0;
               wake_id_in    = '0;
               status_in     = STATUS_OK;
               rsp_valid_in  = 1'b1;
               if (req_chan.func == FUNC_ACQUIRE) begin
                  if (qstat.full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_dec;
                     if (count_dec >= 0) begin
                        granted_in = 1'b1;
                     end else begin
                        queued_in  = 1'b1;
                        qctrl.push = 1'b1;
                     end
                  end
               end else begin
                  if (count_ff >= COUNT_MAX) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     count_in = count_inc;
                     if (count_inc <= 0 && qstat.nonempty) begin
                        // waiter id arrives from memory next cycle
                        wake_valid_in = 1'b1;
                        qctrl.pop     = 1'b1;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_WAKE;
                     end
                  end
               end
               count_now_in = count_in;
            end
         end
         ST_WAKE: begin
            wake_id_in   = qstat.head_id;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         count_in    = $signed({1'b0, csr_wr_data});
         qctrl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff    <= granted_in;
      queued_ff     <= queued_in;
      wake_valid_ff <= wake_valid_in;
      wake_id_ff    <= wake_id_in;
      status_ff     <= status_in;
      count_now_ff  <= count_now_in;
   end

   assign req_chan.ready      = free;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.granted    = granted_ff;
   assign rsp_chan.queued     = queued_ff;
   assign rsp_chan.wake_valid = wake_valid_ff;
   assign rsp_chan.wake_id    = wake_id_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.count_now  = count_now_ff;
endmodule

FILE: rtl/core/csq_ram.sv
module csq_ram #(
   parameter int unsigned WIDTH  = 4,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/csq_queue.sv
module csq_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  csq_pkg::queue_ctrl_type ctrl,
   output csq_pkg::queue_stat_type stat
);
   import csq_pkg::*;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ID_W-1:0]   rd_id;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return idx + IDX_W'(1);
   endfunction

   // the head entry is always being read through a registered port, so a pop finds it in the next cycle
   csq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_ids (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (tail_ff),
      .wr_data (ctrl.push_id),
      .rd_addr (head_ff),
      .rd_data (rd_id)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (ctrl.push) begin
         tail_in = wrap_next(tail_ff);
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl.pop) begin
         head_in = wrap_next(head_ff);
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign stat.full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign stat.nonempty = (fill_ff != '0);
   assign stat.head_id  = rd_id;
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import csq_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic               granted;
      logic               queued;
      logic               wake_valid;
      logic [ID_W-1:0]    wake_id;
      status_type         status;
      logic [COUNT_W-1:0] count_now;
   } sem_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [INIT_W-1:0] csr_wr_data;

   csq_req_if req_chan ();
   csq_rsp_if rsp_chan ();

   counting_semaphore_wait_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the semaphore
   logic signed [COUNT_W-1:0] model_count;
   logic [ID_W-1:0]           model_waiters[$];

   sem_result_type pending_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 37;
   int rsp_idle_pct = 53;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic sem_result_type predict_semaphore(func_type f, logic [ID_W-1:0] id);
      sem_result_type r;
      r = '0;
      r.status = STATUS_OK;
      if (f == FUNC_ACQUIRE) begin
         if (model_waiters.size() >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            model_count = model_count - 9'sd1;
            if (model_count >= 0) begin
               r.granted = 1'b1;
            end else begin
               model_waiters.push_back(id);
               r.queued = 1'b1;
            end
         end
      end else begin
         if (model_count >= COUNT_MAX) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            model_count = model_count + 9'sd1;
            if (model_count <= 0 && model_waiters.size() > 0) begin
               r.wake_id = model_waiters.pop_front();
               r.wake_valid = 1'b1;
            end
         end
      end
      r.count_now = model_count;
      return r;
   endfunction

   always @(posedge clock) begin
      sem_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_chan.granted !== exp_r.granted) begin
               $error("granted expected %0d got %0d", exp_r.granted, rsp_chan.granted);
               error_count++;
            end
            if (rsp_chan.queued !== exp_r.queued) begin
               $error("queued expected %0d got %0d", exp_r.queued, rsp_chan.queued);
               error_count++;
            end
            if (rsp_chan.wake_valid !== exp_r.wake_valid) begin
               $error("wake_valid expected %0d got %0d", exp_r.wake_valid,
                      rsp_chan.wake_valid);
               error_count++;
            end
            if (rsp_chan.wake_id !== exp_r.wake_id) begin
               $error("wake_id expected %0d got %0d", exp_r.wake_id, rsp_chan.wake_id);
               error_count++;
            end
            if (rsp_chan.status !== exp_r.status) begin
               $error("status expected %0d got %0d", exp_r.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.count_now !== exp_r.count_now) begin
               $error("count_now expected %0d got %0d", $signed(exp_r.count_now),
                      $signed(rsp_chan.count_now));
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input func_type f, input logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.func         <= f;
      req_chan.requester_id <= id;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(predict_semaphore(f, id));
   endtask

   // hold off the sender until every response is back
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_initial_count(input logic [INIT_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      model_count = $signed({1'b0, value});
      model_waiters.delete();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_count();
      send_request(FUNC_ACQUIRE, 4'd0);
      send_request(FUNC_RELEASE, 4'd0);
   endtask

   task automatic test_queue_full_and_wake();
      write_initial_count(8'd0);
      send_request(FUNC_ACQUIRE, 4'd15);
      send_request(FUNC_ACQUIRE, 4'd0);
      for (int i = 2; i < QUEUE_DEPTH; i++) send_request(FUNC_ACQUIRE, 4'(i * 7));
      // queue is full now, state must hold
      send_request(FUNC_ACQUIRE, 4'd9);
      repeat (3) send_request(FUNC_RELEASE, 4'd15);
   endtask

   task automatic test_count_overflow();
      write_initial_count(8'd255);
      send_request(FUNC_RELEASE, 4'd3);
      send_request(FUNC_ACQUIRE, 4'd15);
      send_request(FUNC_RELEASE, 4'd0);
      send_request(FUNC_RELEASE, 4'd15);
   endtask

   task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
      int sent;
      int seg_len;
      int acq_pct;
      int pick;
      logic [INIT_W-1:0] init_val;
      func_type f;
      send_idle_pct = s_pct;
      rsp_idle_pct  = r_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(9);
         case (pick)
            0: begin
               init_val = 8'd255;
            end
            1: begin
               init_val = 8'(250 + $urandom_range(4));
            end
            2: begin
               init_val = 8'($urandom_range(255));
            end
            default: begin
               init_val = 8'($urandom_range(4));
            end
         endcase
         write_initial_count(init_val);
         if (init_val >= 8'd250) acq_pct = 25;
         else if (init_val <= 8'd4) acq_pct = ($urandom_range(1) != 0) ? 75 : 50;
         else acq_pct = 50;
         seg_len = 40 + $urandom_range(40);
         for (int i = 0; i < seg_len && sent < n_items; i++) begin
            f = ($urandom_range(99) < acq_pct) ? FUNC_ACQUIRE : FUNC_RELEASE;
            send_request(f, 4'($urandom_range(15)));
            sent++;
            if ($urandom_range(49) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_ACQUIRE;
      req_chan.requester_id = '0;
      rsp_chan.ready        = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      model_count           = COUNT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_count();
      test_queue_full_and_wake();
      test_count_overflow();
      test_random_traffic(400, 37, 53);
      test_random_traffic(400, 53, 37);
      test_random_traffic(400, 0, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/csq_pkg.sv
rtl/core/csq_req_if.sv
rtl/core/csq_rsp_if.sv
rtl/core/csq_ram.sv
rtl/core/csq_queue.sv
rtl/core/counting_semaphore_wait_queue.sv
test/tb_top.sv
